// File: rtl/kecd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kecd_pkg
// Shared types, constants and helpers of the key event queue with chord detect.
// ----------------------------------------------------------------------------
package kecd_pkg;

	// default sizes
	localparam int FIFO_DEPTH_DEF  = 16;
	localparam int KEY_CODES_DEF   = 128;
	localparam int CHORD_SLOTS_DEF = 4;
	localparam int CHORD_KEYS_DEF  = 4;

	// fixed register layout
	localparam int SLOT_MAX  = 4;
	localparam int KEY_MAX   = 4;
	localparam int SLOT_W    = 2;
	localparam int POS_W     = 2;
	localparam int LEN_W     = 3;
	localparam int CODE_W    = 8;
	localparam int TYPE_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;
	localparam int CNT_W     = 32;

	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_SCAN  = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	localparam logic [TYPE_W-1:0] EV_PRESS   = 2'd0;
	localparam logic [TYPE_W-1:0] EV_RELEASE = 2'd1;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEYS_A  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEYS_B  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEYS_C  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEYS_D  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTHS = 3'd5;

	// control from the sequencer to the chord unit
	typedef struct packed {
		logic              rearm;
		logic [CODE_W-1:0] rearm_key;
		logic [SLOT_W-1:0] look_slot;
		logic [POS_W-1:0]  look_pos;
		logic              scan_clear;
		logic              chk;
		logic [SLOT_W-1:0] chk_slot;
		logic [POS_W-1:0]  chk_pos;
		logic              chk_held;
		logic              commit;
	} chord_ctl_t;

	// code 0 and codes at or above the map size are never held
	function automatic logic key_ok(input logic [CODE_W-1:0] k, input int codes);
		return (k != '0) && ({1'b0, k} < (CODE_W+1)'(codes));
	endfunction

endpackage
`default_nettype wire

// File: rtl/key_event_queue_with_chord_detect_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_event_queue_with_chord_detect_core
// Keyboard event queue with a held-key map and chord slot detection.
// ----------------------------------------------------------------------------
// The block takes one request transaction at a time (push, pop, scan or
// query) and returns exactly one result transaction for each. Events live in
// a FIFO_DEPTH-entry synchronous memory and the held-key map in a
// KEY_CODES-entry one-bit synchronous memory, each with one registered read
// port. A push, pop or query goes from acceptance to the done state, which
// loads the result register; a scan first passes through the scan state,
// which looks up every slot key in the held map through its single read
// port, one lookup per cycle, and the wait state before the done state. A
// finished result sits in an output register, so the next request is
// accepted while it waits; that request then holds until the waiting result
// is taken. After reset the held map is cleared with a pass over all
// KEY_CODES entries during which no request is accepted; configuration
// writes are taken at any time (cfg_ready is always high) but must only be
// issued while the block is idle. Writing chord_enable clears every slot's
// fired flag. Key codes of 0 or at or above KEY_CODES are queued but never
// counted as held.
// ----------------------------------------------------------------------------
module key_event_queue_with_chord_detect_core
	import kecd_pkg::*;
#(
	parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
	parameter int KEY_CODES   = KEY_CODES_DEF,
	parameter int CHORD_SLOTS = CHORD_SLOTS_DEF,
	parameter int CHORD_KEYS  = CHORD_KEYS_DEF,
	localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// request channel
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire logic [1:0]           kind,
	input  wire logic [TYPE_W-1:0]    event_type,
	input  wire logic [CODE_W-1:0]    key,
	// result channel
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic                 ok,
	output      logic [TYPE_W-1:0]    out_event_type,
	output      logic [CODE_W-1:0]    out_key,
	output      logic                 key_held,
	output      logic [SLOT_MAX-1:0]  fired_mask,
	output      logic [CW-1:0]        pending,
	output      logic [CNT_W-1:0]     dropped_total,
	output      logic [CNT_W-1:0]     pushed_total,
	output      logic [CNT_W-1:0]     popped_total,
	// configuration channel
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int PW = AW + 1;
	localparam int HW = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1;
	localparam logic [PW-1:0]     PTR_LAST  = PW'(2 * FIFO_DEPTH - 1);
	localparam logic [PW-1:0]     PTR_HALF  = PW'(FIFO_DEPTH);
	localparam logic [PW:0]       PTR_MOD   = (PW+1)'(2 * FIFO_DEPTH);
	localparam logic [CW-1:0]     DEPTH_CNT = CW'(FIFO_DEPTH);
	localparam logic [HW-1:0]     CLR_LAST  = HW'(KEY_CODES - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CHORD_SLOTS - 1);
	localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(CHORD_KEYS - 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_WAIT  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t st_q, st_d;

	// latched request
	kind_t             kind_q;
	logic [TYPE_W-1:0] etype_q;
	logic [CODE_W-1:0] key_q;

	// queue and counters
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  drop_cnt_q, push_cnt_q, pop_cnt_q;
	logic [HW-1:0]     clr_cnt_q;
	logic [SLOT_W-1:0] scan_slot_q;
	logic [POS_W-1:0]  scan_pos_q;

	// scan lookup pipeline
	logic              chk_s1;
	logic [SLOT_W-1:0] chk_slot_s1;
	logic [POS_W-1:0]  chk_pos_s1;
	logic              chk_kv_s1;

	// result register
	logic              out_valid_q;
	logic              ok_q, held_q;
	logic [TYPE_W-1:0] otype_q;
	logic [CODE_W-1:0] okey_q;
	logic [SLOT_MAX-1:0] fired_q;
	logic [CW-1:0]     pend_q;

	logic              in_acc, finish, last_look;
	kind_t             in_kind;
	logic [PW:0]       pend_full;
	logic [CW-1:0]     pend_cur, pend_after;
	logic              fifo_full, fifo_empty;
	logic [AW-1:0]     wr_idx, rd_idx;
	logic [PW-1:0]     wr_off, rd_off;
	logic              push_ok, pop_ok, q_key_ok;

	logic              fifo_we, fifo_re;
	logic [TYPE_W+CODE_W-1:0] fifo_rdata;
	logic              held_we, held_wdata, held_re, held_rdata;
	logic [HW-1:0]     held_waddr, held_raddr;

	chord_ctl_t        cctl;
	logic [CODE_W-1:0] look_key;
	logic [SLOT_MAX-1:0] fired_now;

	assign in_kind   = kind_t'(kind);
	assign in_ready  = (st_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign finish    = (st_q == ST_DONE) && (!out_valid_q || out_ready);
	assign last_look = (scan_slot_q == SLOT_LAST) && (scan_pos_q == POS_LAST);

	// occupancy from the wrap-around pointers
	assign pend_full  = (wr_ptr_q >= rd_ptr_q) ? ({1'b0, wr_ptr_q} - {1'b0, rd_ptr_q})
	                                           : ({1'b0, wr_ptr_q} + PTR_MOD - {1'b0, rd_ptr_q});
	assign pend_cur   = pend_full[CW-1:0];
	assign fifo_full  = (pend_cur >= DEPTH_CNT);
	assign fifo_empty = (pend_cur == '0);
	assign wr_off     = wr_ptr_q - PTR_HALF;
	assign rd_off     = rd_ptr_q - PTR_HALF;
	assign wr_idx     = (wr_ptr_q < PTR_HALF) ? wr_ptr_q[AW-1:0] : wr_off[AW-1:0];
	assign rd_idx     = (rd_ptr_q < PTR_HALF) ? rd_ptr_q[AW-1:0] : rd_off[AW-1:0];

	assign push_ok    = (kind_q == KIND_PUSH) && !fifo_full;
	assign pop_ok     = (kind_q == KIND_POP) && !fifo_empty;
	assign q_key_ok   = key_ok(key_q, KEY_CODES);
	assign pend_after = push_ok ? pend_cur + CW'(1) : (pop_ok ? pend_cur - CW'(1) : pend_cur);

	// sequencer
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR: if (clr_cnt_q == CLR_LAST) st_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc) st_d = (in_kind == KIND_SCAN) ? ST_SCAN : ST_DONE;
			end
			ST_SCAN:  if (last_look) st_d = ST_WAIT;
			ST_WAIT:  st_d = ST_DONE;
			ST_DONE:  if (finish) st_d = ST_IDLE;
			default:  st_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_cnt_q   <= '0;
			scan_slot_q <= '0;
			scan_pos_q  <= '0;
			chk_s1      <= 1'b0;
		end else begin
			st_q   <= st_d;
			chk_s1 <= (st_q == ST_SCAN);
			if (st_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + HW'(1);
			end
			// walk slot keys in order, one held-map lookup per cycle
			if (in_acc) begin
				scan_slot_q <= '0;
				scan_pos_q  <= '0;
			end else if (st_q == ST_SCAN) begin
				if (scan_pos_q == POS_LAST) begin
					scan_pos_q  <= '0;
					scan_slot_q <= scan_slot_q + SLOT_W'(1);
				end else begin
					scan_pos_q <= scan_pos_q + POS_W'(1);
				end
			end
		end
	end

	// lookup tag is registered so it lines up with the memory read data
	always_ff @(posedge clk) begin
		chk_slot_s1 <= scan_slot_q;
		chk_pos_s1  <= scan_pos_q;
		chk_kv_s1   <= key_ok(look_key, KEY_CODES);
	end

	// latched request payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q  <= in_kind;
			etype_q <= event_type;
			key_q   <= key;
		end
	end

	// pointers and totals move only when a transaction finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			drop_cnt_q <= '0;
			push_cnt_q <= '0;
			pop_cnt_q  <= '0;
		end else if (finish) begin
			if (push_ok) begin
				wr_ptr_q   <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
				push_cnt_q <= push_cnt_q + CNT_W'(1);
			end else if (kind_q == KIND_PUSH) begin
				drop_cnt_q <= drop_cnt_q + CNT_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q  <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
				pop_cnt_q <= pop_cnt_q + CNT_W'(1);
			end
		end
	end

	// event memory: write on a finishing push, read as soon as a pop arrives
	assign fifo_we = finish && push_ok;
	assign fifo_re = in_acc && (in_kind == KIND_POP);

	kecd_fifo_mem #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_fifo_mem (
		.clk     (clk),
		.wr_en   (fifo_we),
		.wr_addr (wr_idx),
		.wr_data ({etype_q, key_q}),
		.rd_en   (fifo_re),
		.rd_addr (rd_idx),
		.rd_data (fifo_rdata)
	);

	// held map: clearing pass, then press/release writes; reads for query or scan.
	// nothing reads while a write is pending since one request runs at a time
	always_comb begin
		held_we    = 1'b0;
		held_waddr = clr_cnt_q;
		held_wdata = 1'b0;
		if (st_q == ST_CLEAR) begin
			held_we = 1'b1;
		end else if (finish && (kind_q == KIND_PUSH) && q_key_ok
		             && ((etype_q == EV_PRESS) || (etype_q == EV_RELEASE))) begin
			held_we    = 1'b1;
			held_waddr = key_q[HW-1:0];
			held_wdata = (etype_q == EV_PRESS);
		end
	end

	assign held_re    = (in_acc && (in_kind == KIND_QUERY)) || (st_q == ST_SCAN);
	assign held_raddr = (st_q == ST_SCAN) ? look_key[HW-1:0] : key[HW-1:0];

	kecd_held_mem #(
		.KEY_CODES (KEY_CODES)
	) u_held_mem (
		.clk     (clk),
		.wr_en   (held_we),
		.wr_addr (held_waddr),
		.wr_data (held_wdata),
		.rd_en   (held_re),
		.rd_addr (held_raddr),
		.rd_data (held_rdata)
	);

	// chord unit control
	always_comb begin
		cctl            = '0;
		cctl.rearm      = finish && (kind_q == KIND_PUSH) && q_key_ok && (etype_q == EV_RELEASE);
		cctl.rearm_key  = key_q;
		cctl.look_slot  = scan_slot_q;
		cctl.look_pos   = scan_pos_q;
		cctl.scan_clear = in_acc && (in_kind == KIND_SCAN);
		cctl.chk        = chk_s1;
		cctl.chk_slot   = chk_slot_s1;
		cctl.chk_pos    = chk_pos_s1;
		cctl.chk_held   = chk_kv_s1 && held_rdata;
		cctl.commit     = finish && (kind_q == KIND_SCAN);
	end

	kecd_chord #(
		.CHORD_SLOTS (CHORD_SLOTS),
		.CHORD_KEYS  (CHORD_KEYS)
	) u_chord (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (cctl),
		.look_key  (look_key),
		.fired_now (fired_now)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			ok_q    <= push_ok || pop_ok;
			otype_q <= pop_ok ? fifo_rdata[TYPE_W+CODE_W-1:CODE_W] : '0;
			okey_q  <= pop_ok ? fifo_rdata[CODE_W-1:0] : '0;
			held_q  <= (kind_q == KIND_QUERY) && q_key_ok && held_rdata;
			fired_q <= (kind_q == KIND_SCAN) ? fired_now : '0;
			pend_q  <= pend_after;
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_q;
	assign out_event_type = otype_q;
	assign out_key        = okey_q;
	assign key_held       = held_q;
	assign fired_mask     = fired_q;
	assign pending        = pend_q;
	assign dropped_total  = drop_cnt_q;
	assign pushed_total   = push_cnt_q;
	assign popped_total   = pop_cnt_q;

	// queue occupancy never exceeds its depth
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cur <= DEPTH_CNT)
		else $error("queue occupancy above depth");

	// one request at a time: no acceptance right after an acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("request accepted while another is in flight");

	// a new result only appears after the sequencer finishes
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q == ST_DONE))
		else $error("result without a finished transaction");

	// fired mask is only reported for scans
	a_fired_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && (kind_q != KIND_SCAN)) |=> (fired_mask == '0))
		else $error("fired mask set on a non-scan transaction");

endmodule
`default_nettype wire

// File: rtl/kecd_fifo_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kecd_fifo_mem
// Event storage of the queue: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kecd_fifo_mem
	import kecd_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
	localparam int DW = TYPE_W + CODE_W
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output      logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [FIFO_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/kecd_held_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kecd_held_mem
// Held-key bit map: one bit per key code, one write port, registered read.
// ----------------------------------------------------------------------------
module kecd_held_mem
	import kecd_pkg::*;
#(
	parameter int KEY_CODES = KEY_CODES_DEF,
	localparam int HW = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [HW-1:0] wr_addr,
	input  wire logic          wr_data,
	input  wire logic          rd_en,
	input  wire logic [HW-1:0] rd_addr,
	output      logic          rd_data
);

	logic mem [KEY_CODES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/kecd_chord.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kecd_chord
// Chord slot registers, fired flags, re-arm on release and scan accumulation.
// ----------------------------------------------------------------------------
module kecd_chord
	import kecd_pkg::*;
#(
	parameter int CHORD_SLOTS = CHORD_SLOTS_DEF,
	parameter int CHORD_KEYS  = CHORD_KEYS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire chord_ctl_t           ctl,
	output      logic [CODE_W-1:0]    look_key,
	output      logic [SLOT_MAX-1:0]  fired_now
);

	logic [SLOT_MAX-1:0]            enable_q;
	logic [KEY_MAX*CODE_W-1:0]      keys_q [SLOT_MAX];
	logic [SLOT_MAX*LEN_W-1:0]      lengths_q;
	logic [SLOT_MAX-1:0]            fired_q;
	logic [SLOT_MAX-1:0]            all_q;
	logic [SLOT_MAX-1:0]            active;
	logic [SLOT_MAX-1:0]            rearm_hit;
	logic [LEN_W-1:0]               len [SLOT_MAX];

	always_comb begin
		for (int s = 0; s < SLOT_MAX; s++) begin
			len[s]       = lengths_q[s*LEN_W +: LEN_W];
			active[s]    = (s < CHORD_SLOTS) && enable_q[s] && (len[s] != '0)
			               && (len[s] <= LEN_W'(CHORD_KEYS));
			rearm_hit[s] = 1'b0;
			for (int j = 0; j < KEY_MAX; j++) begin
				if ((LEN_W'(j) < len[s]) && (keys_q[s][j*CODE_W +: CODE_W] == ctl.rearm_key)) begin
					rearm_hit[s] = 1'b1;
				end
			end
		end
	end

	assign look_key  = keys_q[ctl.look_slot][ctl.look_pos*CODE_W +: CODE_W];
	assign fired_now = active & ~fired_q & all_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= '0;
			lengths_q <= '0;
			for (int s = 0; s < SLOT_MAX; s++) begin
				keys_q[s] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:  enable_q  <= cfg_data[SLOT_MAX-1:0];
				REG_KEYS_A:  keys_q[0] <= cfg_data;
				REG_KEYS_B:  keys_q[1] <= cfg_data;
				REG_KEYS_C:  keys_q[2] <= cfg_data;
				REG_KEYS_D:  keys_q[3] <= cfg_data;
				REG_LENGTHS: lengths_q <= cfg_data[SLOT_MAX*LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// fired flags and per-slot all-held accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fired_q <= '0;
			all_q   <= '1;
		end else begin
			if (cfg_we && (cfg_index == REG_ENABLE)) begin
				fired_q <= '0;
			end else if (ctl.rearm) begin
				fired_q <= fired_q & ~(active & rearm_hit);
			end else if (ctl.commit) begin
				fired_q <= fired_q | fired_now;
			end
			if (ctl.scan_clear) begin
				all_q <= '1;
			end else if (ctl.chk && (LEN_W'(ctl.chk_pos) < len[ctl.chk_slot])
			             && !ctl.chk_held) begin
				all_q[ctl.chk_slot] <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: verif/key_event_queue_with_chord_detect_core_tb.sv
// ----------------------------------------------------------------------------
// key_event_queue_with_chord_detect_core_tb
// Self-checking bench for the key event queue: directed corner requests, then
// phases of random push/pop/scan/query traffic under changing chord setups,
// with random stalls on both channels and one long receiver hold-off. Each
// result is checked field by field against an in-bench model of the event
// queue, the held-key map and the chord slots.
// ----------------------------------------------------------------------------
module key_event_queue_with_chord_detect_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kecd_pkg::*;

	localparam int FIFO_DEPTH   = FIFO_DEPTH_DEF;
	localparam int KEY_CODES    = KEY_CODES_DEF;
	localparam int CHORD_SLOTS  = CHORD_SLOTS_DEF;
	localparam int CHORD_KEYS   = CHORD_KEYS_DEF;
	localparam int PTR_W        = $clog2(2 * FIFO_DEPTH);
	localparam int CW           = $clog2(FIFO_DEPTH + 1);
	localparam int KEY_IDX_W    = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1;
	// slowest request is a scan: one map lookup per slot key plus overhead
	localparam int SCAN_LATENCY = CHORD_SLOTS * CHORD_KEYS + 3;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_OFF     = 300;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 50;

	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	// event types that only pass through the queue
	localparam logic [TYPE_W-1:0] EV_OTHER_LO = 2'd2;
	localparam logic [TYPE_W-1:0] EV_OTHER_HI = 2'd3;

	typedef struct packed {
		kind_t             op;
		logic [TYPE_W-1:0] ev_type;
		logic [CODE_W-1:0] code;
	} key_request_t;

	typedef struct packed {
		logic                ok;
		logic [TYPE_W-1:0]   ev_type;
		logic [CODE_W-1:0]   code;
		logic                held;
		logic [SLOT_MAX-1:0] fired;
		logic [CW-1:0]       pending;
		logic [CNT_W-1:0]    drops;
		logic [CNT_W-1:0]    pushes;
		logic [CNT_W-1:0]    pops;
	} key_result_t;

	// dut ports, inputs all known from time zero
	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 in_valid       = 1'b0;
	logic                 in_ready;
	logic [1:0]           kind           = '0;
	logic [TYPE_W-1:0]    event_type     = '0;
	logic [CODE_W-1:0]    key            = '0;
	logic                 out_valid;
	logic                 out_ready      = 1'b0;
	logic                 ok;
	logic [TYPE_W-1:0]    out_event_type;
	logic [CODE_W-1:0]    out_key;
	logic                 key_held;
	logic [SLOT_MAX-1:0]  fired_mask;
	logic [CW-1:0]        pending;
	logic [CNT_W-1:0]     dropped_total;
	logic [CNT_W-1:0]     pushed_total;
	logic [CNT_W-1:0]     popped_total;
	logic                 cfg_valid      = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index      = '0;
	logic [CFG_W-1:0]     cfg_data       = '0;

	// model of the block: event queue, held keys, chord slots, counters
	logic [TYPE_W-1:0]     ev_store_type [FIFO_DEPTH] = '{default: '0};
	logic [CODE_W-1:0]     ev_store_code [FIFO_DEPTH] = '{default: '0};
	logic [PTR_W-1:0]      ev_wr          = '0;
	logic [PTR_W-1:0]      ev_rd          = '0;
	logic [KEY_CODES-1:0]  held_keys      = '0;
	logic [SLOT_MAX-1:0]   slot_spent     = '0;
	logic [CNT_W-1:0]      drop_cnt       = '0;
	logic [CNT_W-1:0]      push_cnt       = '0;
	logic [CNT_W-1:0]      pop_cnt        = '0;
	logic [SLOT_MAX-1:0]   chord_en       = '0;
	logic [CFG_W-1:0]      chord_codes [SLOT_MAX] = '{default: '0};
	logic [3*SLOT_MAX-1:0] chord_len      = '0;

	// stimulus and scoreboard bookkeeping
	key_request_t request_queue [$];
	key_result_t  expected_results [$];
	key_request_t next_req;
	int           req_sent      = 0;
	int           req_taken     = 0;
	int           results_seen  = 0;
	int           fail_count    = 0;
	int           cycle_count   = 0;
	int           send_gap      = 0;
	int           take_gap      = 0;
	int           hold_left     = 0;
	int           hold_asked    = 0;
	int           hold_granted  = 0;
	bit           quiet         = 1'b0;

	key_event_queue_with_chord_detect_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.event_type     (event_type),
		.key            (key),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ok             (ok),
		.out_event_type (out_event_type),
		.out_key        (out_key),
		.key_held       (key_held),
		.fired_mask     (fired_mask),
		.pending        (pending),
		.dropped_total  (dropped_total),
		.pushed_total   (pushed_total),
		.popped_total   (popped_total),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// model helpers
	// ------------------------------------------------------------------------

	// code 0 and codes past the map are never held
	function automatic bit code_valid(logic [CODE_W-1:0] c);
		return c != '0 && c < KEY_CODES;
	endfunction

	function automatic bit code_held(logic [CODE_W-1:0] c);
		return code_valid(c) && held_keys[c[KEY_IDX_W-1:0]];
	endfunction

	function automatic int slot_len(int s);
		return int'(chord_len[3*s +: 3]);
	endfunction

	// a slot with length 0 or above the key count acts as disabled
	function automatic bit slot_live(int s);
		return chord_en[s] && slot_len(s) >= 1 && slot_len(s) <= CHORD_KEYS;
	endfunction

	function automatic logic [CODE_W-1:0] slot_code(int s, int j);
		return chord_codes[s][CODE_W*j +: CODE_W];
	endfunction

	// advance the model by one request and return the result it must produce
	function automatic key_result_t predict_key_result(key_request_t r);
		key_result_t  res;
		logic [PTR_W-1:0] fill;
		bit           all_held;
		res = '0;
		case (r.op)
		KIND_PUSH: begin
			if (code_valid(r.code)) begin
				if (r.ev_type == EV_PRESS) begin
					held_keys[r.code[KEY_IDX_W-1:0]] = 1'b1;
				end else if (r.ev_type == EV_RELEASE) begin
					held_keys[r.code[KEY_IDX_W-1:0]] = 1'b0;
					// releasing any member key re-arms the slot
					for (int s = 0; s < CHORD_SLOTS; s++)
						if (slot_live(s))
							for (int j = 0; j < slot_len(s); j++)
								if (slot_code(s, j) == r.code)
									slot_spent[s] = 1'b0;
				end
			end
			fill = ev_wr - ev_rd;
			if (fill >= FIFO_DEPTH) begin
				drop_cnt++;
			end else begin
				ev_store_type[ev_wr[PTR_W-2:0]] = r.ev_type;
				ev_store_code[ev_wr[PTR_W-2:0]] = r.code;
				ev_wr++;
				push_cnt++;
				res.ok = 1'b1;
			end
		end
		KIND_POP: begin
			if (ev_wr != ev_rd) begin
				res.ev_type = ev_store_type[ev_rd[PTR_W-2:0]];
				res.code    = ev_store_code[ev_rd[PTR_W-2:0]];
				ev_rd++;
				pop_cnt++;
				res.ok = 1'b1;
			end
		end
		KIND_SCAN: begin
			for (int s = 0; s < CHORD_SLOTS; s++) begin
				if (slot_live(s) && !slot_spent[s]) begin
					all_held = 1'b1;
					for (int j = 0; j < slot_len(s); j++)
						if (!code_held(slot_code(s, j)))
							all_held = 1'b0;
					if (all_held) begin
						slot_spent[s] = 1'b1;
						res.fired[s]  = 1'b1;
					end
				end
			end
		end
		default: begin
			res.held = code_held(r.code);
		end
		endcase
		res.pending = CW'(ev_wr - ev_rd);
		res.drops   = drop_cnt;
		res.pushes  = push_cnt;
		res.pops    = pop_cnt;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
				results_seen, what, got, want);
	endtask

	// ------------------------------------------------------------------------
	// monitor: config and request acceptance feed the model, results are checked
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		key_request_t seen;
		key_result_t  want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_ENABLE: begin
					// any enable write re-arms every slot
					chord_en   = cfg_data[SLOT_MAX-1:0];
					slot_spent = '0;
				end
				REG_KEYS_A:  chord_codes[0] = cfg_data;
				REG_KEYS_B:  chord_codes[1] = cfg_data;
				REG_KEYS_C:  chord_codes[2] = cfg_data;
				REG_KEYS_D:  chord_codes[3] = cfg_data;
				REG_LENGTHS: chord_len = cfg_data[3*SLOT_MAX-1:0];
				default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				seen.op      = kind_t'(kind);
				seen.ev_type = event_type;
				seen.code    = key;
				expected_results.push_back(predict_key_result(seen));
				req_taken++;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("result transaction with nothing outstanding", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (ok !== want.ok)
						report_mismatch("ok", CNT_W'(ok), CNT_W'(want.ok));
					if (out_event_type !== want.ev_type)
						report_mismatch("out_event_type", CNT_W'(out_event_type),
							CNT_W'(want.ev_type));
					if (out_key !== want.code)
						report_mismatch("out_key", CNT_W'(out_key), CNT_W'(want.code));
					if (key_held !== want.held)
						report_mismatch("key_held", CNT_W'(key_held), CNT_W'(want.held));
					if (fired_mask !== want.fired)
						report_mismatch("fired_mask", CNT_W'(fired_mask), CNT_W'(want.fired));
					if (pending !== want.pending)
						report_mismatch("pending", CNT_W'(pending), CNT_W'(want.pending));
					if (dropped_total !== want.drops)
						report_mismatch("dropped_total", dropped_total, want.drops);
					if (pushed_total !== want.pushes)
						report_mismatch("pushed_total", pushed_total, want.pushes);
					if (popped_total !== want.pops)
						report_mismatch("popped_total", popped_total, want.pops);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// request driver: holds a transaction until taken, random idle bursts
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && !(in_valid && req_taken != req_sent)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (request_queue.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(1, 7) - 1;
				in_valid <= 1'b0;
			end else if (request_queue.size() != 0) begin
				next_req = request_queue.pop_front();
				kind       <= next_req.op;
				event_type <= next_req.ev_type;
				key        <= next_req.code;
				in_valid   <= 1'b1;
				req_sent++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// result receiver: random stall bursts, plus a long hold-off on request
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_asked != hold_granted) begin
			hold_granted++;
			hold_left = HOLD_OFF;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (take_gap > 0) begin
			take_gap--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			take_gap = $urandom_range(1, 7) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("key_event_queue_with_chord_detect_core test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic void add_req(kind_t op, logic [TYPE_W-1:0] et, logic [CODE_W-1:0] code);
		key_request_t r;
		r.op      = op;
		r.ev_type = et;
		r.code    = code;
		request_queue.push_back(r);
	endfunction

	// pop and scan ignore type and key, so those carry noise
	function automatic void add_noisy(kind_t op);
		add_req(op, TYPE_W'($urandom), CODE_W'($urandom));
	endfunction

	// mostly a small pool so chords actually complete, sometimes anything
	function automatic logic [CODE_W-1:0] pick_code();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 14)
			return CODE_W'($urandom_range(1, 6));
		if (roll < 15)
			return CODE_W'(KEY_CODES - 1);
		if (roll < 16)
			return '0;
		return CODE_W'($urandom_range(0, 255));
	endfunction

	function automatic key_request_t rand_request(int push_w, int pop_w);
		key_request_t r;
		int           roll;
		roll = $urandom_range(0, 99);
		if (roll < push_w)
			r.op = KIND_PUSH;
		else if (roll < push_w + pop_w)
			r.op = KIND_POP;
		else if (roll < push_w + pop_w + (100 - push_w - pop_w) / 2)
			r.op = KIND_SCAN;
		else
			r.op = KIND_QUERY;
		roll = $urandom_range(0, 19);
		if (roll < 9)
			r.ev_type = EV_PRESS;
		else if (roll < 17)
			r.ev_type = EV_RELEASE;
		else
			r.ev_type = $urandom_range(0, 1) ? EV_OTHER_HI : EV_OTHER_LO;
		r.code = pick_code();
		return r;
	endfunction

	// press a slot's keys, scan, break the chord with a release, restore it
	function automatic void queue_chord_play(int s);
		int                n;
		logic [CODE_W-1:0] broken;
		n = slot_len(s);
		if (n < 1 || n > CHORD_KEYS)
			n = CHORD_KEYS;
		for (int j = 0; j < n; j++) begin
			add_req(KIND_PUSH, EV_PRESS, slot_code(s, j));
			if ($urandom_range(0, 2) == 0)
				add_noisy(KIND_POP);
		end
		add_noisy(KIND_SCAN);
		add_noisy(KIND_SCAN);
		broken = slot_code(s, $urandom_range(0, n - 1));
		add_req(KIND_PUSH, EV_RELEASE, broken);
		add_noisy(KIND_SCAN);
		add_req(KIND_QUERY, TYPE_W'($urandom), broken);
		add_req(KIND_PUSH, EV_PRESS, broken);
		add_noisy(KIND_SCAN);
		add_noisy(KIND_POP);
		add_noisy(KIND_POP);
	endfunction

	function automatic logic [CFG_W-1:0] rand_chord_word();
		return {pick_code(), pick_code(), pick_code(), pick_code()};
	endfunction

	// called at a falling edge while idle; valid stays up across the burst
	task automatic program_chords(input logic [SLOT_MAX-1:0] en,
			input logic [CFG_W-1:0] ka, input logic [CFG_W-1:0] kb,
			input logic [CFG_W-1:0] kc, input logic [CFG_W-1:0] kd,
			input logic [3*SLOT_MAX-1:0] lens, input bit spare);
		logic [CFG_IDX_W-1:0] idx [$];
		logic [CFG_W-1:0]     val [$];
		idx = '{REG_KEYS_A, REG_KEYS_B, REG_KEYS_C, REG_KEYS_D, REG_LENGTHS, REG_ENABLE};
		val = '{ka, kb, kc, kd, CFG_W'(lens), CFG_W'(en)};
		if (spare) begin
			idx.push_front(REG_SPARE);
			val.push_front('1);
		end
		foreach (idx[i]) begin
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			cfg_valid <= 1'b1;
			do begin
				@(posedge clk);
			end while (!(cfg_valid && cfg_ready));
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		// hand back at a rising edge so queue fills never race the driver
		@(posedge clk);
	endtask

	// every request taken and every result back
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (request_queue.size() != 0 || req_taken != req_sent
			|| expected_results.size() != 0);
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [SLOT_MAX-1:0]   en;
		logic [CFG_W-1:0]      ka, kb, kc, kd;
		logic [3*SLOT_MAX-1:0] lens;
		int                    push_w, pop_w;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// the held map is cleared after reset before requests are taken
		do begin
			@(negedge clk);
		end while (!in_ready);

		// slot 0 keys 1,2,3; slot 1 holds an invalid code; slot 2 disabled;
		// slot 3 enabled but with a bad length
		program_chords(4'b1011, 32'h0003_0201, 32'h0000_807f, 32'h0000_0001,
			32'h0403_0201, {3'd5, 3'd1, 3'd2, 3'd3}, 1'b1);

		// directed corners
		add_noisy(KIND_POP);                       // pop from empty queue
		add_req(KIND_QUERY, EV_PRESS, 8'd0);       // unknown key
		add_req(KIND_QUERY, EV_RELEASE, 8'd255);
		add_req(KIND_PUSH, EV_PRESS, 8'd0);        // invalid code still queued
		add_req(KIND_PUSH, EV_PRESS, 8'd127);
		add_req(KIND_PUSH, EV_PRESS, 8'd128);      // just past the map
		add_req(KIND_PUSH, EV_PRESS, 8'd255);
		add_req(KIND_QUERY, EV_OTHER_HI, 8'd127);
		add_req(KIND_QUERY, EV_OTHER_LO, 8'd128);
		add_req(KIND_PUSH, EV_RELEASE, 8'd1);      // release of a key not held
		add_req(KIND_PUSH, EV_OTHER_LO, 8'd200);   // pass-through types
		add_req(KIND_PUSH, EV_OTHER_HI, 8'd64);
		add_req(KIND_PUSH, EV_PRESS, 8'd1);
		add_req(KIND_PUSH, EV_PRESS, 8'd2);
		add_req(KIND_PUSH, EV_PRESS, 8'd3);
		add_noisy(KIND_SCAN);                      // slot 0 fires
		add_noisy(KIND_SCAN);                      // already fired, stays quiet
		add_req(KIND_PUSH, EV_RELEASE, 8'd2);      // re-arms slot 0
		add_noisy(KIND_SCAN);
		add_req(KIND_PUSH, EV_PRESS, 8'd2);
		add_noisy(KIND_SCAN);                      // fires again
		add_noisy(KIND_POP);
		add_noisy(KIND_POP);
		add_req(KIND_QUERY, EV_PRESS, 8'd2);
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) begin
				// everything cleared
				en = '0; ka = '0; kb = '0; kc = '0; kd = '0; lens = '0;
			end else if (phase == 1) begin
				// everything set: all codes invalid, all lengths out of range
				en = '1; ka = '1; kb = '1; kc = '1; kd = '1; lens = '1;
			end else if (phase == 2) begin
				// full-width chords on every slot
				en = '1;
				ka = rand_chord_word(); kb = rand_chord_word();
				kc = rand_chord_word(); kd = rand_chord_word();
				lens = {3'd4, 3'd4, 3'd4, 3'd4};
			end else begin
				en = SLOT_MAX'($urandom_range(0, 15));
				ka = rand_chord_word(); kb = rand_chord_word();
				kc = rand_chord_word(); kd = rand_chord_word();
				for (int s = 0; s < SLOT_MAX; s++)
					lens[3*s +: 3] = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(1, 4))
						: 3'($urandom_range(0, 7));
			end
			program_chords(en, ka, kb, kc, kd, lens, 1'b0);

			// alternate balanced, filling and draining traffic
			case (phase % 3)
			0: begin push_w = 35; pop_w = 25; end
			1: begin push_w = 60; pop_w = 10; end
			default: begin push_w = 20; pop_w = 50; end
			endcase
			// no idling at all near the end, and now and then elsewhere
			quiet = (phase >= PHASES - 2) || ($urandom_range(0, 3) == 0);
			if (phase == 4) begin
				// receiver stops for a long while so the block backs up
				hold_asked++;
				push_w = 70;
				pop_w  = 10;
			end

			while (request_queue.size() < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) == 0)
					queue_chord_play($urandom_range(0, CHORD_SLOTS - 1));
				else
					request_queue.push_back(rand_request(push_w, pop_w));
			end
			wait_drained();
		end

		// let any stray late result show up
		repeat (2 * SCAN_LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("key_event_queue_with_chord_detect_core test passed");
		else
			$display("key_event_queue_with_chord_detect_core test failed");
		$finish;
	end

endmodule
